FILE: rtl/xnt_pkg.sv
// Shared types, character constants and result codes for the XML node tokenizer.
// Used by the front end, queue, back end and top level; depends on nothing.
package xnt_pkg;

	localparam logic [31:0] MASK31 = 32'h7FFF_FFFF;
	localparam logic [31:0] CH_LT  = 32'h0000_003C;
	localparam logic [31:0] CH_GT  = 32'h0000_003E;
	localparam logic [31:0] CH_AM  = 32'h0000_0026;
	localparam logic [31:0] CH_SC  = 32'h0000_003B;
	localparam logic [31:0] CH_SL  = 32'h0000_002F;
	localparam logic [31:0] CH_EP  = 32'h0000_0021;
	localparam logic [31:0] CH_LB  = 32'h0000_005B;
	localparam logic [31:0] CH_RB  = 32'h0000_005D;
	localparam logic [31:0] CH_MN  = 32'h0000_002D;
	localparam logic [31:0] CH_SP  = 32'h0000_0020;
	localparam logic [31:0] CH_TAB = 32'h0000_0009;
	localparam logic [31:0] CH_LF  = 32'h0000_000A;
	localparam logic [31:0] CH_CR  = 32'h0000_000D;
	localparam logic [31:0] CH_NUL = 32'h0000_0000;

	localparam logic [2:0] EV_CHAR   = 3'd0;
	localparam logic [2:0] EV_NODE   = 3'd1;
	localparam logic [2:0] EV_SYNTAX = 3'd2;
	localparam logic [2:0] EV_UNTERM = 3'd3;
	localparam logic [2:0] EV_END    = 3'd4;

	localparam logic [1:0] K_TEXT = 2'd0;
	localparam logic [1:0] K_TAG  = 2'd1;
	localparam logic [1:0] K_REF  = 2'd2;
	localparam logic [1:0] K_END  = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0_0000_0000_0001,
		S_TEXT = 13'b0_0000_0000_0010,
		S_STAG = 13'b0_0000_0000_0100,
		S_NTAG = 13'b0_0000_0000_1000,
		S_ETAG = 13'b0_0000_0001_0000,
		S_PTAG = 13'b0_0000_0010_0000,
		S_BTAG = 13'b0_0000_0100_0000,
		S_RTAG = 13'b0_0000_1000_0000,
		S_SREF = 13'b0_0001_0000_0000,
		S_BGCM = 13'b0_0010_0000_0000,
		S_CTAG = 13'b0_0100_0000_0000,
		S_ENCM = 13'b0_1000_0000_0000,
		S_FNCM = 13'b1_0000_0000_0000
	} scan_st_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [30:0] content_char;
		logic [1:0]  node_kind;
		logic        amp_prefix;
		logic [31:0] node_line;
	} result_t;

	// an entry holds the one or two results of one accepted word
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} entry_t;

	function automatic result_t char_res(input logic [31:0] c);
		result_t r;
		r.event_res    = EV_CHAR;
		r.content_char = c[30:0];
		r.node_kind    = K_TEXT;
		r.amp_prefix   = 1'b0;
		r.node_line    = '0;
		return r;
	endfunction

	function automatic result_t node_res(input logic [1:0] kind, input logic amp,
		input logic [31:0] line);
		result_t r;
		r.event_res    = EV_NODE;
		r.content_char = '0;
		r.node_kind    = kind;
		r.amp_prefix   = amp;
		r.node_line    = line;
		return r;
	endfunction

	function automatic result_t code_res(input logic [2:0] ev);
		result_t r;
		r.event_res    = ev;
		r.content_char = '0;
		r.node_kind    = K_TEXT;
		r.amp_prefix   = 1'b0;
		r.node_line    = '0;
		return r;
	endfunction

endpackage

FILE: rtl/xnt_in_if.sv
// Character input channel of the XML node tokenizer.
// Plain valid/ready channel; no package dependency.
interface xnt_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] char_code;
	logic [31:0] line_number;

	modport source(output valid, command, char_code, line_number, input ready);
	modport sink(input valid, command, char_code, line_number, output ready);
endinterface

FILE: rtl/xnt_out_if.sv
// Event output channel of the XML node tokenizer.
// Plain valid/ready channel; no package dependency.
interface xnt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [30:0] content_char;
	logic [1:0]  node_kind;
	logic        amp_prefix;
	logic [31:0] node_line;
	logic        last;

	modport source(output valid, event_res, content_char, node_kind, amp_prefix,
		node_line, last, input ready);
	modport sink(input valid, event_res, content_char, node_kind, amp_prefix,
		node_line, last, output ready);
endinterface

FILE: rtl/xnt_front.sv
// Front end: accepts characters, runs the scanner state machine and builds
// the zero, one or two results of each word. Depends on xnt_pkg and xnt_in_if.
module xnt_front (
	input  logic             clk,
	input  logic             arst_n,
	xnt_in_if.sink           in_ch,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             q_full,
	output logic             push,
	output xnt_pkg::entry_t  push_entry
);

	xnt_pkg::scan_st_t state_q, state_d;
	logic [31:0]       start_line_q, start_line_d;
	logic              resume_q;
	logic              acc;
	logic [1:0]        cnt;
	logic [31:0]       c;
	logic [31:0]       m;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign c           = in_ch.char_code;
	assign m           = c & xnt_pkg::MASK31;

	always_comb begin
		state_d         = state_q;
		start_line_d    = start_line_q;
		cnt             = 2'd0;
		push_entry.r0   = xnt_pkg::code_res(xnt_pkg::EV_END);
		push_entry.r1   = xnt_pkg::code_res(xnt_pkg::EV_END);
		if (in_ch.command) begin
			state_d = xnt_pkg::S_IDLE;
			unique case (state_q)
				xnt_pkg::S_IDLE: begin
					cnt = 2'd1;
				end
				xnt_pkg::S_TEXT: begin
					push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TEXT, 1'b0, start_line_q);
					cnt = 2'd2;
				end
				xnt_pkg::S_SREF: begin
					push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TEXT, 1'b1, start_line_q);
					cnt = 2'd2;
				end
				default: begin
					push_entry.r0 = xnt_pkg::code_res((state_q == xnt_pkg::S_FNCM) ?
						xnt_pkg::EV_UNTERM : xnt_pkg::EV_SYNTAX);
					cnt = resume_q ? 2'd2 : 2'd1;
				end
			endcase
		end else begin
			unique case (state_q)
				xnt_pkg::S_TEXT: begin
					if (c == xnt_pkg::CH_LT || c == xnt_pkg::CH_AM) begin
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TEXT, 1'b0,
							start_line_q);
						cnt          = 2'd1;
						start_line_d = in_ch.line_number;
						state_d      = (c == xnt_pkg::CH_LT) ? xnt_pkg::S_STAG :
							xnt_pkg::S_SREF;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
						cnt = 2'd1;
					end
				end
				xnt_pkg::S_STAG: begin
					priority if (c == xnt_pkg::CH_GT) begin
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TAG, 1'b0, start_line_q);
						cnt     = 2'd1;
						state_d = xnt_pkg::S_IDLE;
					end else if (c == xnt_pkg::CH_SL) begin
						state_d = xnt_pkg::S_ETAG;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
						cnt     = 2'd1;
						state_d = (c == xnt_pkg::CH_EP) ? xnt_pkg::S_PTAG : xnt_pkg::S_NTAG;
					end
				end
				xnt_pkg::S_NTAG, xnt_pkg::S_ETAG: begin
					cnt = 2'd1;
					if (c == xnt_pkg::CH_GT) begin
						push_entry.r0 = xnt_pkg::node_res((state_q == xnt_pkg::S_ETAG) ?
							xnt_pkg::K_END : xnt_pkg::K_TAG, 1'b0, start_line_q);
						state_d = xnt_pkg::S_IDLE;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
					end
				end
				xnt_pkg::S_PTAG: begin
					push_entry.r0 = xnt_pkg::char_res(c);
					cnt = 2'd1;
					priority if (c == xnt_pkg::CH_LB) state_d = xnt_pkg::S_BTAG;
					else if (c == xnt_pkg::CH_MN) state_d = xnt_pkg::S_BGCM;
					else state_d = xnt_pkg::S_NTAG;
				end
				xnt_pkg::S_BTAG: begin
					push_entry.r0 = xnt_pkg::char_res(c);
					cnt = 2'd1;
					if (c == xnt_pkg::CH_RB) state_d = xnt_pkg::S_RTAG;
				end
				xnt_pkg::S_RTAG: begin
					cnt = 2'd1;
					if (c == xnt_pkg::CH_GT) begin
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TAG, 1'b0, start_line_q);
						state_d = xnt_pkg::S_IDLE;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
						if (c != xnt_pkg::CH_RB) state_d = xnt_pkg::S_BTAG;
					end
				end
				xnt_pkg::S_SREF: begin
					priority if (c == xnt_pkg::CH_SC) begin
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_REF, 1'b0, start_line_q);
						cnt     = 2'd1;
						state_d = xnt_pkg::S_IDLE;
					end else if (c == xnt_pkg::CH_LT) begin
						// dangling '&' turns into text, then the tag starts
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TEXT, 1'b1,
							start_line_q);
						cnt          = 2'd1;
						start_line_d = in_ch.line_number;
						state_d      = xnt_pkg::S_STAG;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
						cnt = 2'd1;
					end
				end
				xnt_pkg::S_BGCM: begin
					push_entry.r0 = xnt_pkg::char_res(c);
					cnt     = 2'd1;
					state_d = (c == xnt_pkg::CH_MN) ? xnt_pkg::S_CTAG : xnt_pkg::S_NTAG;
				end
				xnt_pkg::S_CTAG: begin
					push_entry.r0 = xnt_pkg::char_res(c);
					cnt = 2'd1;
					if (c == xnt_pkg::CH_MN) state_d = xnt_pkg::S_ENCM;
				end
				xnt_pkg::S_ENCM: begin
					push_entry.r0 = xnt_pkg::char_res(c);
					cnt     = 2'd1;
					state_d = (c == xnt_pkg::CH_MN) ? xnt_pkg::S_FNCM : xnt_pkg::S_CTAG;
				end
				xnt_pkg::S_FNCM: begin
					cnt = 2'd1;
					if (c == xnt_pkg::CH_GT) begin
						push_entry.r0 = xnt_pkg::node_res(xnt_pkg::K_TAG, 1'b0, start_line_q);
						state_d = xnt_pkg::S_IDLE;
					end else begin
						push_entry.r0 = xnt_pkg::char_res(c);
						state_d = xnt_pkg::S_CTAG;
					end
				end
				default: begin
					// idle: find the start of the next node
					state_d = xnt_pkg::S_IDLE;
					priority if (c == xnt_pkg::CH_LT) begin
						start_line_d = in_ch.line_number;
						state_d      = xnt_pkg::S_STAG;
					end else if (c == xnt_pkg::CH_AM) begin
						start_line_d = in_ch.line_number;
						state_d      = xnt_pkg::S_SREF;
					end else if (c == xnt_pkg::CH_NUL) begin
						cnt = 2'd1;
					end else if (!(m == xnt_pkg::CH_SP || m == xnt_pkg::CH_TAB ||
						m == xnt_pkg::CH_LF || m == xnt_pkg::CH_CR)) begin
						start_line_d  = in_ch.line_number;
						push_entry.r0 = xnt_pkg::char_res(m);
						cnt           = 2'd1;
						state_d       = xnt_pkg::S_TEXT;
					end
				end
			endcase
		end
		push_entry.two = (cnt == 2'd2);
	end

	assign push           = acc && (cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= xnt_pkg::S_IDLE;
			start_line_q <= '0;
			resume_q     <= 1'b0;
		end else begin
			if (acc) begin
				state_q      <= state_d;
				start_line_q <= start_line_d;
			end
			if (cfg_wr_en) resume_q <= cfg_wr_data;
		end
	end

endmodule

FILE: rtl/xnt_queue.sv
// Short queue of result entries between the front and back ends.
// Register-based ring buffer; depends on xnt_pkg.
module xnt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xnt_pkg::entry_t  push_entry,
	input  logic             pop,
	output xnt_pkg::entry_t  head,
	output logic             full,
	output logic             empty
);

	xnt_pkg::entry_t            slot_q [xnt_pkg::QDEPTH];
	logic [xnt_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [xnt_pkg::QAW:0]      cnt_q;
	logic                       do_wr, do_rd;

	assign full  = (cnt_q == (xnt_pkg::QAW+1)'(xnt_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [xnt_pkg::QAW-1:0] nxt(input logic [xnt_pkg::QAW-1:0] p);
		return (p == xnt_pkg::QAW'(xnt_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= nxt(wr_ptr_q);
			if (do_rd) rd_ptr_q <= nxt(rd_ptr_q);
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

FILE: rtl/xnt_back.sv
// Back end: takes entries from the queue and issues their results one word
// at a time from a holding register. Depends on xnt_pkg and xnt_out_if.
module xnt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  xnt_pkg::entry_t  head,
	input  logic             q_empty,
	output logic             pop,
	xnt_out_if.source        out_ch
);

	xnt_pkg::entry_t ent_q;
	logic            has_q;
	logic            idx_q;
	logic            final_word;
	logic            finish;
	xnt_pkg::result_t sel;

	assign final_word = idx_q || !ent_q.two;
	assign finish     = has_q && out_ch.ready && final_word;
	assign pop        = !q_empty && (!has_q || finish);
	assign sel        = idx_q ? ent_q.r1 : ent_q.r0;

	assign out_ch.valid        = has_q;
	assign out_ch.event_res    = sel.event_res;
	assign out_ch.content_char = sel.content_char;
	assign out_ch.node_kind    = sel.node_kind;
	assign out_ch.amp_prefix   = sel.amp_prefix;
	assign out_ch.node_line    = sel.node_line;
	assign out_ch.last         = final_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q <= 1'b0;
			idx_q <= 1'b0;
		end else begin
			priority if (pop) begin
				has_q <= 1'b1;
				idx_q <= 1'b0;
			end else if (finish) begin
				has_q <= 1'b0;
				idx_q <= 1'b0;
			end else if (has_q && out_ch.ready) begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
	end

endmodule

FILE: rtl/xml_node_tokenizer.sv
// XML node tokenizer, top level: front end, entry queue and back end.
// Depends on xnt_pkg, xnt_in_if, xnt_out_if, xnt_front, xnt_queue, xnt_back.
//
// Takes one character word per cycle and emits one event word per cycle when
// not stalled. Each character is resolved by a single scanner state
// transition in the front end, so input is accepted every cycle while the
// four-entry queue has room; a character yields zero, one or two events (two
// only at end of stream, after open text, a dangling '&' or an error in
// resume mode), and the back end drains one event per cycle while the output
// is ready, so sustained input rate equals the output rate when most
// characters produce one event. The user must write resume_on_error through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module xml_node_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	xnt_in_if.sink    char_stream,
	xnt_out_if.source event_stream
);

	logic            push, pop, q_full, q_empty;
	xnt_pkg::entry_t push_entry, head;

	xnt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (char_stream),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	xnt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	xnt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (event_stream)
	);

endmodule
